// File: rtl/bvt_pkg.sv
package bvt_pkg;

	// request codes
	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_FIND_VEC = 2'd1;
	localparam logic [1:0] CMD_FIND_ID  = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_DUP      = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam int unsigned COMP_W = 4;
	localparam int unsigned ID_W   = 7;
	localparam int unsigned VEC_W  = 3 * COMP_W;

	typedef logic [VEC_W-1:0] vec_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [ID_W-1:0]        found_id;
		logic signed [COMP_W-1:0] found_x;
		logic signed [COMP_W-1:0] found_y;
		logic signed [COMP_W-1:0] found_z;
	} resp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// File: rtl/bond_vector_table_unit.sv
// bond vector table: holds up to ID_COUNT vectors (components in
// -MAX_COMPONENT..MAX_COMPONENT) keyed by identifier, in one single-port-write,
// registered-read memory plus a row of valid flops. one request gives one
// result. add and find-by-vector walk the memory linearly, one entry read per
// cycle, and stop early when the walk meets a matching vector; an add that is
// refused up front skips the walk, find-by-id reads its single entry, and clear
// and refused requests go straight to the result. a new request is taken only
// once the previous one has handed its result to the output register.
module bond_vector_table_unit #(
	parameter int unsigned ID_COUNT      = 128,
	parameter int unsigned MAX_COMPONENT = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic signed [bvt_pkg::COMP_W-1:0] vec_x,
	input  logic signed [bvt_pkg::COMP_W-1:0] vec_y,
	input  logic signed [bvt_pkg::COMP_W-1:0] vec_z,
	input  logic [bvt_pkg::ID_W-1:0]      bond_id,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [bvt_pkg::ID_W-1:0]      found_id,
	output logic signed [bvt_pkg::COMP_W-1:0] found_x,
	output logic signed [bvt_pkg::COMP_W-1:0] found_y,
	output logic signed [bvt_pkg::COMP_W-1:0] found_z
);
	import bvt_pkg::*;

	localparam int unsigned IDX_W = $clog2(ID_COUNT);

	mem_ctl_t         mem_ctl;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [IDX_W-1:0] mem_wr_addr;
	vec_t             mem_wr_data;
	vec_t             mem_rd_data;

	logic  res_valid;
	logic  res_free;
	resp_t res;

	logic  out_valid_q;
	resp_t out_q;

	// sequencer: decodes the request, runs the scan and keeps the valid row
	bvt_seq #(
		.ID_COUNT      (ID_COUNT),
		.MAX_COMPONENT (MAX_COMPONENT),
		.IDX_W         (IDX_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (in_valid),
		.req_stall   (in_stall),
		.req_cmd     (cmd),
		.req_x       (vec_x),
		.req_y       (vec_y),
		.req_z       (vec_z),
		.req_id      (bond_id),
		.res_valid   (res_valid),
		.res_free    (res_free),
		.res         (res),
		.mem_ctl     (mem_ctl),
		.mem_rd_addr (mem_rd_addr),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_data (mem_rd_data)
	);

	// vector storage, contents undefined until written
	bvt_vec_mem #(
		.DEPTH  (ID_COUNT),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.rd_addr (mem_rd_addr),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	// output register: free when empty or being taken this cycle
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign found_id  = out_q.found_id;
	assign found_x   = out_q.found_x;
	assign found_y   = out_q.found_y;
	assign found_z   = out_q.found_z;

endmodule

// File: rtl/bvt_vec_mem.sv
module bvt_vec_mem #(
	parameter int unsigned DEPTH  = 128,
	parameter int unsigned ADDR_W = 7
) (
	input  logic               clk,
	input  bvt_pkg::mem_ctl_t  ctl,
	input  logic [ADDR_W-1:0]  rd_addr,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  bvt_pkg::vec_t      wr_data,
	output bvt_pkg::vec_t      rd_data
);
	import bvt_pkg::*;

	vec_t mem_q [DEPTH];
	vec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/bvt_seq.sv
module bvt_seq #(
	parameter int unsigned ID_COUNT      = 128,
	parameter int unsigned MAX_COMPONENT = 4,
	parameter int unsigned IDX_W         = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    req_cmd,
	input  logic signed [bvt_pkg::COMP_W-1:0] req_x,
	input  logic signed [bvt_pkg::COMP_W-1:0] req_y,
	input  logic signed [bvt_pkg::COMP_W-1:0] req_z,
	input  logic [bvt_pkg::ID_W-1:0]      req_id,
	output logic                          res_valid,
	input  logic                          res_free,
	output bvt_pkg::resp_t                res,
	output bvt_pkg::mem_ctl_t             mem_ctl,
	output logic [IDX_W-1:0]              mem_rd_addr,
	output logic [IDX_W-1:0]              mem_wr_addr,
	output bvt_pkg::vec_t                 mem_wr_data,
	input  bvt_pkg::vec_t                 mem_rd_data
);
	import bvt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_PUT   = 2'd3;

	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(ID_COUNT - 1);
	localparam logic [8:0]         ID_LIMIT = 9'(ID_COUNT);
	localparam logic signed [4:0]  MAXC     = 5'(MAX_COMPONENT);

	logic [1:0]          state_q;
	logic [ID_COUNT-1:0] valid_q;
	logic [1:0]          cmd_q;
	vec_t                vec_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    scan_q;
	logic                issued_all_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    addr_s1;
	resp_t               res_q;

	logic             accept;
	logic             ranged;
	logic             id_ok;
	logic [IDX_W-1:0] id_idx;
	logic             hit;
	logic             scan_end;

	function automatic logic comp_ok(input logic signed [COMP_W-1:0] c);
		logic signed [4:0] w;
		w = 5'(c);
		return (w <= MAXC) && (w >= -MAXC);
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign ranged    = comp_ok(req_x) && comp_ok(req_y) && comp_ok(req_z);
	assign id_ok     = (9'(req_id) < ID_LIMIT);
	assign id_idx    = IDX_W'(req_id);

	// compare stage sees the entry read in the previous cycle
	assign hit      = vld_s1 && valid_q[addr_s1] && (mem_rd_data == vec_q);
	assign scan_end = vld_s1 && (addr_s1 == LAST_IDX);

	always_comb begin
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		mem_rd_addr   = scan_q;
		mem_wr_addr   = idx_q;
		mem_wr_data   = vec_q;
		if (state_q == S_IDLE) begin
			mem_rd_addr   = id_idx;
			mem_ctl.rd_en = accept && (req_cmd == CMD_FIND_ID) && id_ok;
		end else if (state_q == S_SCAN) begin
			mem_ctl.rd_en = !issued_all_q && !hit;
			mem_ctl.wr_en = (cmd_q == CMD_ADD) && !hit && scan_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			scan_q       <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					scan_q       <= '0;
					issued_all_q <= 1'b0;
					vld_s1       <= 1'b0;
					if (accept) begin
						case (req_cmd)
							CMD_ADD: begin
								if (ranged && id_ok && !valid_q[id_idx]) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_PUT;
								end
							end
							CMD_FIND_VEC: state_q <= ranged ? S_SCAN : S_PUT;
							CMD_FIND_ID: begin
								if (id_ok && valid_q[id_idx]) begin
									state_q <= S_FETCH;
								end else begin
									state_q <= S_PUT;
								end
							end
							default: begin
								valid_q <= '0;
								state_q <= S_PUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit || scan_end) begin
						vld_s1  <= 1'b0;
						state_q <= S_PUT;
						if (!hit && (cmd_q == CMD_ADD)) begin
							valid_q[idx_q] <= 1'b1;
						end
					end else begin
						vld_s1 <= !issued_all_q;
						if (!issued_all_q) begin
							scan_q <= scan_q + 1'b1;
							if (scan_q == LAST_IDX) begin
								issued_all_q <= 1'b1;
							end
						end
					end
				end
				S_FETCH: state_q <= S_PUT;
				S_PUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			addr_s1 <= scan_q;
		end
		if (accept) begin
			cmd_q <= req_cmd;
			vec_q <= {req_x, req_y, req_z};
			idx_q <= id_idx;
			res_q.found_id <= '0;
			res_q.found_x  <= '0;
			res_q.found_y  <= '0;
			res_q.found_z  <= '0;
			case (req_cmd)
				CMD_ADD: begin
					if (!ranged || !id_ok) begin
						res_q.status <= STAT_RANGE;
					end else if (valid_q[id_idx]) begin
						res_q.status <= STAT_DUP;
					end else begin
						res_q.status <= STAT_OK;
					end
				end
				CMD_FIND_VEC: res_q.status <= STAT_NOTFOUND;
				CMD_FIND_ID: begin
					res_q.status <= (id_ok && valid_q[id_idx]) ? STAT_OK : STAT_NOTFOUND;
				end
				default: res_q.status <= STAT_OK;
			endcase
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				if (cmd_q == CMD_ADD) begin
					res_q.status <= STAT_DUP;
				end else begin
					res_q.status   <= STAT_OK;
					res_q.found_id <= ID_W'(addr_s1);
				end
			end
		end else if (state_q == S_FETCH) begin
			res_q.found_x <= mem_rd_data[VEC_W-1 -: COMP_W];
			res_q.found_y <= mem_rd_data[COMP_W +: COMP_W];
			res_q.found_z <= mem_rd_data[COMP_W-1:0];
		end
	end

	assign res_valid = (state_q == S_PUT);
	assign res       = res_q;

endmodule
